@@ rtl/dsbf_pkg.sv @@
// package: shared constants, types and defaults for the disk sector bitstream formatter
`default_nettype none
package dsbf_pkg;

  localparam int SECTOR_BYTES_DEF = 400;
  localparam int GAP_BITS_DEF     = 120;
  localparam int SYNC_BITS_DEF    = 88;

  localparam int GAP_BITS_MAX     = 255;
  localparam int SYNC_BITS_MAX    = 255;

  localparam int CHUNK_BITS       = 64;
  localparam int CNT_W            = 7;
  localparam int SHAMT_W          = 6;
  localparam int WORD_W           = 33;
  localparam int ADDR_W           = 16;
  localparam int BYTE_W           = 8;
  localparam int BCNT_W           = 9;
  localparam int EXP_W            = 9;
  localparam int LEN_W            = $clog2(2 * GAP_BITS_MAX + 2 * SYNC_BITS_MAX + 2 * ADDR_W + 1);
  localparam int DIFF_W           = LEN_W + 1;

  localparam logic [15:0] CRC_FILL = 16'hCCCC;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  // one request's bit stream: word w sits at exponent e, tail adds a final one
  typedef struct packed {
    logic [WORD_W-1:0] w;
    logic [EXP_W-1:0]  e;
    logic [LEN_W-1:0]  len;
    logic              tail;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/dsbf_hdr.sv @@
// sector state tracking and decode of one request into a bit stream description
`default_nettype none
module dsbf_hdr #(
  parameter int SECTOR_BYTES = dsbf_pkg::SECTOR_BYTES_DEF,
  parameter int GAP_BITS     = dsbf_pkg::GAP_BITS_DEF,
  parameter int SYNC_BITS    = dsbf_pkg::SYNC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           acc,
  input  wire logic                           kind,
  input  wire logic [8:0]                     cylinder,
  input  wire logic                           head,
  input  wire logic [3:0]                     sector,
  input  wire logic [dsbf_pkg::BYTE_W-1:0]    data_byte,
  output dsbf_pkg::job_t                      job,
  output logic                                keep
);

  logic                          in_sector_r, in_sector_nxt;
  logic [dsbf_pkg::BCNT_W-1:0]   bytes_r, bytes_nxt;
  logic [dsbf_pkg::BCNT_W-1:0]   bytes_inc;
  logic                          done;
  logic [dsbf_pkg::ADDR_W-1:0]   addr;

  assign addr      = {cylinder[7:0], 3'b000, head, sector};
  assign bytes_inc = bytes_r + dsbf_pkg::BCNT_W'(1);
  assign done      = {1'b0, bytes_inc} >= (dsbf_pkg::BCNT_W + 1)'(SECTOR_BYTES);

  always_comb begin
    keep          = 1'b1;
    in_sector_nxt = in_sector_r;
    bytes_nxt     = bytes_r;
    job           = '0;
    if (kind == dsbf_pkg::KIND_START) begin
      job.w         = {1'b1, addr, ~addr};
      job.e         = dsbf_pkg::EXP_W'(GAP_BITS + SYNC_BITS);
      job.len       = dsbf_pkg::LEN_W'(2 * GAP_BITS + 2 * SYNC_BITS + 2 * dsbf_pkg::ADDR_W);
      job.tail      = 1'b1;
      in_sector_nxt = 1'b1;
      bytes_nxt     = '0;
    end else begin
      keep = in_sector_r;
      if (done) begin
        job.w         = {(dsbf_pkg::WORD_W - dsbf_pkg::BYTE_W - 16)'(0), data_byte,
                         dsbf_pkg::CRC_FILL};
        job.e         = dsbf_pkg::EXP_W'(GAP_BITS / 2);
        job.len       = dsbf_pkg::LEN_W'(dsbf_pkg::BYTE_W + 16 + GAP_BITS / 2);
        in_sector_nxt = 1'b0;
        bytes_nxt     = '0;
      end else begin
        job.w     = {(dsbf_pkg::WORD_W - dsbf_pkg::BYTE_W)'(0), data_byte};
        job.e     = '0;
        job.len   = dsbf_pkg::LEN_W'(dsbf_pkg::BYTE_W);
        bytes_nxt = bytes_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sector_r <= 1'b0;
      bytes_r     <= '0;
    end else if (acc && keep) begin
      in_sector_r <= in_sector_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dsbf_chunk.sv @@
// job register and 64-bit chunk generator with registered output
`default_nettype none
module dsbf_chunk (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire dsbf_pkg::job_t                   job,
  output logic                                  busy,
  input  wire logic                             out_stall,
  output logic                                  out_valid,
  output logic [dsbf_pkg::CHUNK_BITS-1:0]       out_bits,
  output logic [dsbf_pkg::CNT_W-1:0]            out_bit_count,
  output logic                                  out_last
);

  logic                               job_vld_r;
  logic [dsbf_pkg::WORD_W-1:0]        w_r;
  logic [dsbf_pkg::EXP_W-1:0]         e_r;
  logic [dsbf_pkg::LEN_W-1:0]         rem_r;
  logic                               tail_r;

  logic                               fire;
  logic [dsbf_pkg::CNT_W-1:0]         n;
  logic [dsbf_pkg::LEN_W-1:0]         r;
  logic                               fin;
  logic signed [dsbf_pkg::DIFF_W-1:0] d;
  logic [dsbf_pkg::DIFF_W-1:0]        nd;
  logic [dsbf_pkg::CHUNK_BITS-1:0]    wx;
  logic [dsbf_pkg::CHUNK_BITS-1:0]    sh;
  logic [dsbf_pkg::CHUNK_BITS-1:0]    mask;
  logic [dsbf_pkg::CHUNK_BITS-1:0]    chunk;

  assign fire = job_vld_r && (!out_valid || !out_stall);
  assign n    = (rem_r >= dsbf_pkg::LEN_W'(dsbf_pkg::CHUNK_BITS))
                ? dsbf_pkg::CNT_W'(dsbf_pkg::CHUNK_BITS) : dsbf_pkg::CNT_W'(rem_r);
  assign r    = rem_r - dsbf_pkg::LEN_W'(n);
  assign fin  = (r == '0);
  assign busy = job_vld_r && !(fire && fin);

  assign d  = $signed(dsbf_pkg::DIFF_W'(e_r)) - $signed(dsbf_pkg::DIFF_W'(r));
  assign nd = dsbf_pkg::DIFF_W'(0) - dsbf_pkg::DIFF_W'(d);
  assign wx = dsbf_pkg::CHUNK_BITS'(w_r);

  always_comb begin
    sh = '0;
    if (!d[dsbf_pkg::DIFF_W-1]) begin
      if (d < dsbf_pkg::DIFF_W'(dsbf_pkg::CHUNK_BITS)) begin
        sh = wx << d[dsbf_pkg::SHAMT_W-1:0];
      end
    end else if (nd < dsbf_pkg::DIFF_W'(dsbf_pkg::CHUNK_BITS)) begin
      sh = wx >> nd[dsbf_pkg::SHAMT_W-1:0];
    end
    if (n == dsbf_pkg::CNT_W'(dsbf_pkg::CHUNK_BITS)) begin
      mask = '1;
    end else begin
      mask = (dsbf_pkg::CHUNK_BITS'(1) << n[dsbf_pkg::SHAMT_W-1:0]) - dsbf_pkg::CHUNK_BITS'(1);
    end
    chunk    = sh & mask;
    chunk[0] = chunk[0] | (tail_r && fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        job_vld_r <= 1'b1;
      end else if (fire && fin) begin
        job_vld_r <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_r    <= job.w;
      e_r    <= job.e;
      rem_r  <= job.len;
      tail_r <= job.tail;
    end else if (fire) begin
      rem_r <= r;
    end
    if (fire) begin
      out_bits      <= chunk;
      out_bit_count <= n;
      out_last      <= fin;
    end
  end

endmodule
`default_nettype wire

@@ rtl/disk_sector_bitstream_formatter.sv @@
// top level: disk sector bitstream formatter
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_stall in_kind in_cylinder in_head      | request in
//          | in_sector in_data_byte                             |
//  out     | out_valid out_stall out_bits out_bit_count out_last| chunks out
//
// a request is decoded in the cycle it is taken; one 64-bit chunk per unstalled cycle
// a data byte in a sector gives one chunk (two, or three with a long gap, if last),
// a header ceil((2*GAP_BITS + 2*SYNC_BITS + 32) / 64) chunks, 17 at most
// the next request is taken in the cycle the previous one's last chunk is made
// reset clears the sector state, the job valid flag and out_valid
// out_stall holds the output register and, through it, the chunk generator
`default_nettype none
module disk_sector_bitstream_formatter #(
  parameter int SECTOR_BYTES = dsbf_pkg::SECTOR_BYTES_DEF,
  parameter int GAP_BITS     = dsbf_pkg::GAP_BITS_DEF,
  parameter int SYNC_BITS    = dsbf_pkg::SYNC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic [8:0]                        in_cylinder,
  input  wire logic                              in_head,
  input  wire logic [3:0]                        in_sector,
  input  wire logic [dsbf_pkg::BYTE_W-1:0]       in_data_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [dsbf_pkg::CHUNK_BITS-1:0]        out_bits,
  output logic [dsbf_pkg::CNT_W-1:0]             out_bit_count,
  output logic                                   out_last
);

  logic           acc;
  logic           keep;
  logic           busy;
  dsbf_pkg::job_t job;

  assign in_stall = busy;
  assign acc      = in_valid && !busy;

  dsbf_hdr #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .GAP_BITS     (GAP_BITS),
    .SYNC_BITS    (SYNC_BITS)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_kind),
    .cylinder  (in_cylinder),
    .head      (in_head),
    .sector    (in_sector),
    .data_byte (in_data_byte),
    .job       (job),
    .keep      (keep)
  );

  dsbf_chunk u_chunk (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (acc && keep),
    .job           (job),
    .busy          (busy),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_bits      (out_bits),
    .out_bit_count (out_bit_count),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

@@ tb/disk_sector_bitstream_formatter_tb.sv @@
`timescale 1ns / 1ps
// testbench for the disk sector bitstream formatter: random requests, chunk-level checking
module disk_sector_bitstream_formatter_tb;

  localparam int SECT_BYTES  = dsbf_pkg::SECTOR_BYTES_DEF;
  localparam int GAP         = dsbf_pkg::GAP_BITS_DEF;
  localparam int SYNC        = dsbf_pkg::SYNC_BITS_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS       = 280;

  // builds the track bits of each request and holds the chunks still due
  class track_chunk_board;
    bit                              in_sec;
    int unsigned                     byte_cnt;
    bit                              stream_bits[$];
    logic [dsbf_pkg::CHUNK_BITS-1:0] due_bits[$];
    logic [dsbf_pkg::CNT_W-1:0]      due_count[$];
    logic                            due_last[$];
    int                              errors;

    function void add_zeros(int n);
      repeat (n) stream_bits.push_back(1'b0);
    endfunction

    function void add_word(logic [31:0] w, int n);
      int i;
      for (i = n - 1; i >= 0; i--) stream_bits.push_back(w[i]);
    endfunction

    function void add_sync();
      add_zeros(SYNC - 1);
      stream_bits.push_back(1'b1);
    endfunction

    function void push_chunk(logic [dsbf_pkg::CHUNK_BITS-1:0] b, int n);
      due_bits.push_back(b);
      due_count.push_back(n[dsbf_pkg::CNT_W-1:0]);
      due_last.push_back(1'b0);
    endfunction

    function void take_request(dsbf_pkg::kind_t k, logic [8:0] cyl, logic hd,
                               logic [3:0] sec, logic [dsbf_pkg::BYTE_W-1:0] db);
      logic [dsbf_pkg::ADDR_W-1:0]     addr;
      logic [dsbf_pkg::CHUNK_BITS-1:0] acc;
      int                              cnt;
      int                              made;
      stream_bits.delete();
      if (k == dsbf_pkg::KIND_START) begin
        // cylinder bit 8 falls off the 16-bit address
        addr = {cyl[7:0], 3'b000, hd, sec};
        add_zeros(GAP);
        add_sync();
        add_word(addr, dsbf_pkg::ADDR_W);
        add_word(~addr, dsbf_pkg::ADDR_W);
        add_zeros(GAP);
        add_sync();
        in_sec = 1'b1;
        byte_cnt = 0;
      end else if (in_sec) begin
        add_word(db, dsbf_pkg::BYTE_W);
        byte_cnt = (byte_cnt + 1) % 512;
        if (byte_cnt >= SECT_BYTES) begin
          add_word(dsbf_pkg::CRC_FILL, 16);
          add_zeros(GAP / 2);
          in_sec = 1'b0;
          byte_cnt = 0;
        end
      end
      acc = '0;
      cnt = 0;
      made = 0;
      foreach (stream_bits[i]) begin
        acc = {acc[dsbf_pkg::CHUNK_BITS-2:0], stream_bits[i]};
        cnt++;
        if (cnt == dsbf_pkg::CHUNK_BITS) begin
          push_chunk(acc, cnt);
          made++;
          acc = '0;
          cnt = 0;
        end
      end
      if (cnt > 0) begin
        push_chunk(acc, cnt);
        made++;
      end
      if (made > 0) due_last[due_last.size() - 1] = 1'b1;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_chunk(logic [dsbf_pkg::CHUNK_BITS-1:0] b, logic [dsbf_pkg::CNT_W-1:0] c,
                     logic l);
      logic [dsbf_pkg::CHUNK_BITS-1:0] eb;
      logic [dsbf_pkg::CNT_W-1:0]      ec;
      logic                            el;
      if (due_bits.size() == 0) begin
        report($sformatf("chunk bits=%h count=%0d with nothing due", b, c));
        return;
      end
      eb = due_bits.pop_front();
      ec = due_count.pop_front();
      el = due_last.pop_front();
      if (b !== eb) report($sformatf("bits %h, due %h", b, eb));
      if (c !== ec) report($sformatf("bit_count %0d, due %0d", c, ec));
      if (l !== el) report($sformatf("last %b, due %b", l, el));
    endtask

    function int pending();
      return due_bits.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [8:0] in_cylinder;
  logic in_head;
  logic [3:0] in_sector;
  logic [dsbf_pkg::BYTE_W-1:0] in_data_byte;
  logic out_valid;
  logic out_stall;
  logic [dsbf_pkg::CHUNK_BITS-1:0] out_bits;
  logic [dsbf_pkg::CNT_W-1:0] out_bit_count;
  logic out_last;

  track_chunk_board board = new();
  int reqs_sent = 0;
  int chunks_seen = 0;
  int send_calm = 0;
  int idle_run = 0;

  disk_sector_bitstream_formatter #(
    .SECTOR_BYTES(SECT_BYTES),
    .GAP_BITS(GAP),
    .SYNC_BITS(SYNC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_cylinder(in_cylinder),
    .in_head(in_head),
    .in_sector(in_sector),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_bits(out_bits),
    .out_bit_count(out_bit_count),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(dsbf_pkg::kind_t k, logic [8:0] cyl, logic hd, logic [3:0] sec,
                          logic [dsbf_pkg::BYTE_W-1:0] db);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_cylinder <= cyl;
    in_head <= hd;
    in_sector <= sec;
    in_data_byte <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_request(k, cyl, hd, sec, db);
    reqs_sent++;
  endtask

  task automatic send_byte(logic [dsbf_pkg::BYTE_W-1:0] db);
    send_req(dsbf_pkg::KIND_DATA, 9'($urandom), 1'($urandom), 4'($urandom), db);
  endtask

  task automatic send_header(logic [8:0] cyl, logic hd, logic [3:0] sec);
    send_req(dsbf_pkg::KIND_START, cyl, hd, sec, 8'($urandom));
  endtask

  // result side: check every chunk taken, random stall runs, one long hold-off
  initial begin
    int free_left;
    int stall_left;
    int hold_left;
    bit held;
    free_left = 0;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_chunk(out_bits, out_bit_count, out_last);
        chunks_seen++;
      end
      if (!held && chunks_seen >= 150) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        stall_left = idle_cycles();
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int run;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = dsbf_pkg::KIND_START;
    in_cylinder = '0;
    in_head = 1'b0;
    in_sector = '0;
    in_data_byte = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // data outside a sector is dropped
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_header(9'd0, 1'b0, 4'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    // new header inside an open sector, cylinder high bit dropped
    send_header(9'd511, 1'b1, 4'd15);
    send_byte(8'hA5);
    send_header(9'd256, 1'b0, 4'd0);
    send_header(9'd255, 1'b1, 4'd15);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_header(9'h0AA, 1'b0, 4'd5);
    send_byte(8'h7E);

    // random sectors, each abandoned by the next header
    while (reqs_sent < ITEMS) begin
      send_header(9'($urandom), 1'($urandom), 4'($urandom));
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 25);
      repeat (run) send_byte(8'($urandom));
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
